// ===== rtl/utlpm_pkg.sv =====
// Shared types and constants for the unibit trie longest-prefix match block.
`default_nettype none

package utlpm_pkg;

	localparam int ADDR_BITS  = 32;
	localparam int NODE_COUNT = 1024;
	localparam int HOP_BITS   = 16;
	localparam int IDX_BITS   = $clog2(NODE_COUNT);
	localparam int CNT_BITS   = $clog2(NODE_COUNT + 1);
	localparam int LEN_BITS   = 6;
	localparam int STAT_BITS  = 2;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef enum logic [STAT_BITS-1:0] {
		ST_HIT    = 2'd0,
		ST_MISS   = 2'd1,
		ST_INS_OK = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic                valid;
		logic [HOP_BITS-1:0] hop;
		logic [IDX_BITS-1:0] left;
		logic [IDX_BITS-1:0] right;
	} node_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;
		logic step;
		logic emit;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic walk_end;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/utlpm_datapath.sv =====
// Datapath: node memory, root node, walk registers and result register.
`default_nettype none

module utlpm_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire utlpm_pkg::ctl_cmd_t             ctl,
	output utlpm_pkg::dp_status_t                sts,
	input  wire logic                            cmd,
	input  wire logic [utlpm_pkg::ADDR_BITS-1:0] key_bits,
	input  wire logic [utlpm_pkg::LEN_BITS-1:0]  key_length,
	input  wire logic [utlpm_pkg::HOP_BITS-1:0]  next_hop,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output logic [utlpm_pkg::STAT_BITS-1:0]      status,
	output logic [utlpm_pkg::HOP_BITS-1:0]       matched_hop,
	output logic [utlpm_pkg::LEN_BITS-1:0]       levels_walked
);

	utlpm_pkg::node_t mem [utlpm_pkg::NODE_COUNT];
	utlpm_pkg::node_t mem_rd_q;
	utlpm_pkg::node_t root_q;
	utlpm_pkg::node_t cur_q;
	logic [utlpm_pkg::IDX_BITS-1:0]  idx_q;
	logic                            from_mem_q;
	logic [utlpm_pkg::CNT_BITS-1:0]  used_q;
	utlpm_pkg::cmd_t                 op_q;
	logic [utlpm_pkg::ADDR_BITS-1:0] key_q;
	logic [utlpm_pkg::LEN_BITS-1:0]  len_q;
	logic [utlpm_pkg::LEN_BITS-1:0]  bit_q;
	logic [utlpm_pkg::HOP_BITS-1:0]  hop_q;
	logic                            found_q;
	logic [utlpm_pkg::HOP_BITS-1:0]  best_q;
	logic [utlpm_pkg::LEN_BITS-1:0]  levels_q;
	utlpm_pkg::status_t              res_status_q;
	logic [utlpm_pkg::HOP_BITS-1:0]  res_hop_q;
	logic [utlpm_pkg::LEN_BITS-1:0]  res_levels_q;
	logic                            out_valid_q;

	utlpm_pkg::node_t                node_now;
	utlpm_pkg::node_t                wr_node;
	logic                            dir;
	logic [utlpm_pkg::IDX_BITS-1:0]  child;
	logic                            at_end;
	logic                            pool_full;
	logic                            found_nx;
	logic [utlpm_pkg::HOP_BITS-1:0]  best_nx;
	logic                            wr_en;
	logic                            rd_en;
	logic                            descend;
	logic                            alloc;
	logic                            walk_end;
	utlpm_pkg::status_t              end_status;
	logic [utlpm_pkg::HOP_BITS-1:0]  end_hop;
	logic [utlpm_pkg::LEN_BITS-1:0]  end_levels;
	logic [utlpm_pkg::LEN_BITS-1:0]  len_clamped;

	assign len_clamped = (key_length > utlpm_pkg::LEN_BITS'(utlpm_pkg::ADDR_BITS)) ?
		utlpm_pkg::LEN_BITS'(utlpm_pkg::ADDR_BITS) : key_length;

	// current node comes from the memory read port right after a descend
	assign node_now  = from_mem_q ? mem_rd_q : cur_q;
	assign dir       = key_q[utlpm_pkg::ADDR_BITS-1];
	assign child     = dir ? node_now.right : node_now.left;
	assign at_end    = (bit_q == len_q);
	assign pool_full = (used_q == utlpm_pkg::CNT_BITS'(utlpm_pkg::NODE_COUNT));
	assign found_nx  = found_q | node_now.valid;
	assign best_nx   = node_now.valid ? node_now.hop : best_q;

	always_comb begin
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		descend    = 1'b0;
		alloc      = 1'b0;
		walk_end   = 1'b0;
		wr_node    = node_now;
		end_status = utlpm_pkg::ST_INS_OK;
		end_hop    = '0;
		end_levels = '0;
		if (op_q == utlpm_pkg::CMD_LOOKUP) begin
			end_status = found_nx ? utlpm_pkg::ST_HIT : utlpm_pkg::ST_MISS;
			end_hop    = found_nx ? best_nx : '0;
			end_levels = at_end ? levels_q : levels_q + utlpm_pkg::LEN_BITS'(1);
			if (at_end || child == '0) begin
				walk_end = 1'b1;
			end else begin
				descend = 1'b1;
				rd_en   = 1'b1;
			end
		end else begin
			if (at_end) begin
				walk_end      = 1'b1;
				wr_en         = 1'b1;
				wr_node.valid = 1'b1;
				wr_node.hop   = hop_q;
			end else if (child != '0) begin
				descend = 1'b1;
				rd_en   = 1'b1;
			end else if (pool_full) begin
				// keep any freshly allocated node that has not been stored yet
				walk_end   = 1'b1;
				wr_en      = 1'b1;
				end_status = utlpm_pkg::ST_FULL;
			end else begin
				alloc = 1'b1;
				wr_en = 1'b1;
				if (dir) begin
					wr_node.right = used_q[utlpm_pkg::IDX_BITS-1:0];
				end else begin
					wr_node.left = used_q[utlpm_pkg::IDX_BITS-1:0];
				end
			end
		end
		if (!ctl.step) begin
			wr_en    = 1'b0;
			rd_en    = 1'b0;
			descend  = 1'b0;
			alloc    = 1'b0;
			walk_end = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && idx_q != '0) begin
			mem[idx_q] <= wr_node;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_q <= mem[child];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q      <= '0;
			used_q      <= utlpm_pkg::CNT_BITS'(1);
			from_mem_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en && idx_q == '0) begin
				root_q <= wr_node;
			end
			if (alloc) begin
				used_q <= used_q + utlpm_pkg::CNT_BITS'(1);
			end
			if (ctl.start || alloc) begin
				from_mem_q <= 1'b0;
			end else if (descend) begin
				from_mem_q <= 1'b1;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q     <= utlpm_pkg::cmd_t'(cmd);
			key_q    <= key_bits;
			len_q    <= len_clamped;
			hop_q    <= next_hop;
			bit_q    <= '0;
			levels_q <= '0;
			found_q  <= 1'b0;
			best_q   <= '0;
			cur_q    <= root_q;
			idx_q    <= '0;
		end else if (ctl.step) begin
			found_q <= found_nx;
			best_q  <= best_nx;
			if (descend || alloc) begin
				bit_q <= bit_q + utlpm_pkg::LEN_BITS'(1);
				key_q <= {key_q[utlpm_pkg::ADDR_BITS-2:0], 1'b0};
			end
			if (descend) begin
				idx_q    <= child;
				levels_q <= levels_q + utlpm_pkg::LEN_BITS'(1);
			end
			if (alloc) begin
				cur_q <= '0;
				idx_q <= used_q[utlpm_pkg::IDX_BITS-1:0];
			end
			if (walk_end) begin
				res_status_q <= end_status;
				res_hop_q    <= end_hop;
				res_levels_q <= end_levels;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			status        <= res_status_q;
			matched_hop   <= res_hop_q;
			levels_walked <= res_levels_q;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign sts.walk_end = walk_end;
	assign sts.out_free = !out_valid_q || !rsp_stall;

endmodule

`default_nettype wire

// ===== rtl/utlpm_ctrl.sv =====
// Controller: sequences accept, per-level walk and result delivery.
`default_nettype none

module utlpm_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire utlpm_pkg::dp_status_t  sts,
	output utlpm_pkg::ctl_cmd_t         ctl
);

	utlpm_pkg::state_t state_q;
	utlpm_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= utlpm_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		ctl       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			utlpm_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctl.start = 1'b1;
					state_nx  = utlpm_pkg::S_WALK;
				end
			end
			utlpm_pkg::S_WALK: begin
				ctl.step = 1'b1;
				if (sts.walk_end) begin
					state_nx = utlpm_pkg::S_EMIT;
				end
			end
			utlpm_pkg::S_EMIT: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_nx = utlpm_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = utlpm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/unibit_trie_longest_prefix_match.sv =====
// Top level of the unibit binary trie longest-prefix match engine.
// Each transaction on the request channel is one insert (cmd 0) or one lookup (cmd 1) and
// yields exactly one response transaction. The engine handles one transaction at a time:
// it takes the request, walks the trie level by level (the root plus one level per key bit
// followed, at most 33 levels) and then loads the response register; the walk is paced by
// the single node memory, which returns one node per cycle. Lookups stop early at the first
// missing child. The root lives in flip-flops and the other nodes are handed out in order
// from a fill count, so no clearing pass is needed after reset. A new request is taken as
// soon as the previous response is in the output register, even while that response is
// still stalled.
`default_nettype none

module unibit_trie_longest_prefix_match (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire logic                            cmd,
	input  wire logic [utlpm_pkg::ADDR_BITS-1:0] key_bits,
	input  wire logic [utlpm_pkg::LEN_BITS-1:0]  key_length,
	input  wire logic [utlpm_pkg::HOP_BITS-1:0]  next_hop,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output logic [utlpm_pkg::STAT_BITS-1:0]      status,
	output logic [utlpm_pkg::HOP_BITS-1:0]       matched_hop,
	output logic [utlpm_pkg::LEN_BITS-1:0]       levels_walked
);

	utlpm_pkg::ctl_cmd_t   ctl;
	utlpm_pkg::dp_status_t sts;

	utlpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	utlpm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.key_bits      (key_bits),
		.key_length    (key_length),
		.next_hop      (next_hop),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.matched_hop   (matched_hop),
		.levels_walked (levels_walked)
	);

`ifndef SYNTHESIS
	// response register is never overwritten while a stalled response sits in it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!rsp_valid || !rsp_stall))
		else $error("response loaded over a pending response");

	// one transaction at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while a walk is in flight");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> rsp_valid)
		else $error("response not presented after load");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.start, ctl.step, ctl.emit}))
		else $error("controller issued overlapping commands");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the unibit trie longest-prefix match engine: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
	import utlpm_pkg::*;

	localparam int RANDOM_ITEMS = 1030;
	localparam int GROW_ITEMS   = 550;  // after this, long inserts run the pool dry
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_AT     = 700;
	localparam int SETTLE       = 40;
	localparam int QUIET_LIMIT  = 2000;

	typedef struct packed {
		cmd_t                cmd;
		logic [ADDR_BITS-1:0] key;
		logic [LEN_BITS-1:0]  len;
		logic [HOP_BITS-1:0]  hop;
	} request_t;

	typedef struct packed {
		status_t             status;
		logic [HOP_BITS-1:0] hop;
		logic [LEN_BITS-1:0] levels;
	} route_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		route_t   want;
	} directed_row_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] key;
		logic [LEN_BITS-1:0]  len;
	} prefix_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	cmd_t                 cmd;
	logic [ADDR_BITS-1:0] key_bits;
	logic [LEN_BITS-1:0]  key_length;
	logic [HOP_BITS-1:0]  next_hop;
	logic                 rsp_valid;
	logic                 rsp_stall;
	logic [STAT_BITS-1:0] status;
	logic [HOP_BITS-1:0]  matched_hop;
	logic [LEN_BITS-1:0]  levels_walked;

	// shadow copy of the trie
	bit                  trie_valid[NODE_COUNT];
	logic [HOP_BITS-1:0] trie_hop[NODE_COUNT];
	int unsigned         trie_child[NODE_COUNT][2];
	int unsigned         nodes_used;

	route_t        expected_routes[$];
	prefix_t       known_prefixes[$];
	directed_row_t directed_rows[$];
	int            errors = 0;
	int            sent_count = 0;
	bit            hold_pending = 1'b0;

	unibit_trie_longest_prefix_match uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.key_bits(key_bits),
		.key_length(key_length),
		.next_hop(next_hop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.matched_hop(matched_hop),
		.levels_walked(levels_walked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [ADDR_BITS-1:0] prefix_mask(input int unsigned len);
		return (len == 0) ? '0 : ({ADDR_BITS{1'b1}} << (ADDR_BITS - len));
	endfunction

	// Walks the shadow trie for one transaction and updates it on an insert.
	function automatic route_t predict_route(input request_t r);
		route_t              res;
		int unsigned         len, node, child, b, levels;
		bit                  d, full, found, stop;
		logic [HOP_BITS-1:0] best;
		len  = (r.len > ADDR_BITS) ? ADDR_BITS : r.len;
		node = 0;
		res.hop    = '0;
		res.levels = '0;
		if (r.cmd == CMD_INSERT) begin
			full = 1'b0;
			for (b = 0; b < len && !full; b++) begin
				d     = r.key[ADDR_BITS-1-b];
				child = trie_child[node][d];
				if (child == 0) begin
					if (nodes_used >= NODE_COUNT) begin
						full = 1'b1;
					end else begin
						child = nodes_used;
						nodes_used++;
						trie_valid[child]    = 1'b0;
						trie_hop[child]      = '0;
						trie_child[child][0] = 0;
						trie_child[child][1] = 0;
						trie_child[node][d]  = child;
					end
				end
				if (!full)
					node = child;
			end
			res.status = full ? ST_FULL : ST_INS_OK;
			if (!full) begin
				trie_valid[node] = 1'b1;
				trie_hop[node]   = r.hop;
			end
		end else begin
			found  = 1'b0;
			best   = '0;
			levels = 0;
			b      = 0;
			stop   = 1'b0;
			while (!stop) begin
				if (trie_valid[node]) begin
					found = 1'b1;
					best  = trie_hop[node];
				end
				if (b >= len) begin
					stop = 1'b1;
				end else begin
					levels++;
					node = trie_child[node][r.key[ADDR_BITS-1-b]];
					b++;
					// a step onto a missing child still counts as a level
					if (node == 0)
						stop = 1'b1;
				end
			end
			res.status = found ? ST_HIT : ST_MISS;
			res.hop    = found ? best : '0;
			res.levels = LEN_BITS'(levels);
		end
		return res;
	endfunction

	function automatic request_t next_request(input bit fill);
		request_t             r;
		prefix_t              p;
		logic [ADDR_BITS-1:0] m;
		int unsigned          sel, ext;
		bit                   have;
		have  = known_prefixes.size() > 0;
		r.hop = HOP_BITS'($urandom);
		r.key = $urandom;
		p     = '0;
		if (have)
			p = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
		m = prefix_mask(p.len);
		if ($urandom_range(0, 99) < 45) begin
			r.cmd = CMD_LOOKUP;
			if (have && $urandom_range(0, 3) != 0)
				r.key = (p.key & m) | (r.key & ~m);
			r.len = ($urandom_range(0, 2) == 0) ? LEN_BITS'($urandom_range(0, 63))
				: LEN_BITS'(ADDR_BITS);
		end else begin
			r.cmd = CMD_INSERT;
			sel   = $urandom_range(0, 2);
			if (fill && sel == 0) begin
				r.len = ($urandom_range(0, 3) == 0) ? LEN_BITS'($urandom_range(33, 63))
					: LEN_BITS'(ADDR_BITS);
			end else if (have && sel == 1) begin
				// rewrite an existing route
				r.key = (p.key & m) | (r.key & ~m);
				r.len = p.len;
			end else if (have && sel == 2) begin
				r.key = (p.key & m) | (r.key & ~m);
				ext   = p.len + $urandom_range(1, 4);
				r.len = (ext > ADDR_BITS) ? LEN_BITS'(ADDR_BITS) : LEN_BITS'(ext);
			end else begin
				r.len = LEN_BITS'($urandom_range(0, 8));
			end
		end
		return r;
	endfunction

	task automatic add_row(input cmd_t c, input logic [ADDR_BITS-1:0] k,
			input int unsigned l, input logic [HOP_BITS-1:0] h,
			input int typed, input status_t st, input logic [HOP_BITS-1:0] mh,
			input int unsigned lv);
		directed_row_t row;
		row.req   = '{cmd: c, key: k, len: LEN_BITS'(l), hop: h};
		row.typed = (typed != 0);
		row.want  = '{status: st, hop: mh, levels: LEN_BITS'(lv)};
		directed_rows.push_back(row);
	endtask

	task automatic offer(input request_t r, input bit typed, input route_t want,
			input bit drain);
		int     gap;
		bit     no_idle;
		route_t got;
		no_idle = ((sent_count / 128) % 3) == 2;
		gap     = no_idle ? 0 : $urandom_range(0, 3);
		if (drain || gap > 0) begin
			req_valid <= 1'b0;
			if (drain)
				while (expected_routes.size() != 0)
					@(posedge clk);
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		cmd        <= r.cmd;
		key_bits   <= r.key;
		key_length <= r.len;
		next_hop   <= r.hop;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		got = predict_route(r);
		expected_routes.push_back(typed ? want : got);
		if (r.cmd == CMD_INSERT && got.status == ST_INS_OK)
			known_prefixes.push_back('{key: r.key,
				len: (r.len > ADDR_BITS) ? LEN_BITS'(ADDR_BITS) : r.len});
		sent_count++;
	endtask

	task automatic take_route();
		route_t want;
		if (expected_routes.size() == 0) begin
			$error("response with nothing pending: status %0d", status);
			errors++;
		end else begin
			want = expected_routes.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				errors++;
			end
			if (matched_hop !== want.hop) begin
				$error("matched_hop: expected %h, got %h", want.hop, matched_hop);
				errors++;
			end
			if (levels_walked !== want.levels) begin
				$error("levels_walked: expected %0d, got %0d", want.levels, levels_walked);
				errors++;
			end
		end
	endtask

	initial begin : response_sink
		int gap;
		int taken;
		taken     = 0;
		rsp_stall = 1'b0;
		forever begin
			gap = (((taken / 128) % 3) == 1) ? 0 : $urandom_range(0, 3);
			if (hold_pending) begin
				hold_pending = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
			take_route();
			taken++;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		request_t r;
		route_t   none;
		int       i;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		cmd        = CMD_INSERT;
		key_bits   = '0;
		key_length = '0;
		next_hop   = '0;
		none       = '0;
		for (i = 0; i < NODE_COUNT; i++) begin
			trie_valid[i]    = 1'b0;
			trie_hop[i]      = '0;
			trie_child[i][0] = 0;
			trie_child[i][1] = 0;
		end
		nodes_used = 1;

		// empty trie, default route, long paths, over-long lengths, route rewrites
		add_row(CMD_LOOKUP, 32'h0000_0000, 0, 16'h0000, 1, ST_MISS, 16'h0000, 0);
		add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 32, 16'hFFFF, 1, ST_MISS, 16'h0000, 1);
		add_row(CMD_INSERT, 32'h0000_0000, 0, 16'hFFFF, 1, ST_INS_OK, 16'h0000, 0);
		add_row(CMD_LOOKUP, 32'h0000_0000, 32, 16'h0000, 1, ST_HIT, 16'hFFFF, 1);
		add_row(CMD_INSERT, 32'h8000_0000, 1, 16'h0001, 1, ST_INS_OK, 16'h0000, 0);
		add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 63, 16'h0000, 1, ST_HIT, 16'h0001, 2);
		add_row(CMD_INSERT, 32'hFFFF_FFFF, 32, 16'h1234, 1, ST_INS_OK, 16'h0000, 0);
		add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 32, 16'h0000, 1, ST_HIT, 16'h1234, 32);
		add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 63, 16'hFFFF, 1, ST_HIT, 16'h1234, 32);
		add_row(CMD_LOOKUP, 32'hFFFF_FFFE, 32, 16'h0000, 0, ST_HIT, 16'h0000, 0);
		add_row(CMD_INSERT, 32'h8000_0000, 1, 16'hABCD, 1, ST_INS_OK, 16'h0000, 0);
		add_row(CMD_LOOKUP, 32'h8000_0000, 40, 16'h0000, 0, ST_HIT, 16'h0000, 0);
		add_row(CMD_INSERT, 32'h0000_0000, 32, 16'h0000, 1, ST_INS_OK, 16'h0000, 0);
		add_row(CMD_LOOKUP, 32'h0000_0000, 32, 16'h0000, 1, ST_HIT, 16'h0000, 32);
		add_row(CMD_INSERT, 32'h0000_0000, 63, 16'h5555, 1, ST_INS_OK, 16'h0000, 0);
		add_row(CMD_LOOKUP, 32'h0000_0001, 32, 16'h0000, 0, ST_HIT, 16'h0000, 0);
		add_row(CMD_INSERT, 32'hAAAA_AAAA, 16, 16'h00FF, 1, ST_INS_OK, 16'h0000, 0);
		add_row(CMD_LOOKUP, 32'hAAAA_5555, 32, 16'h0000, 0, ST_HIT, 16'h0000, 0);
		add_row(CMD_LOOKUP, 32'h5555_5555, 0, 16'h0000, 1, ST_HIT, 16'hFFFF, 0);
		add_row(CMD_INSERT, 32'h1234_5678, 63, 16'h8000, 0, ST_HIT, 16'h0000, 0);
		add_row(CMD_LOOKUP, 32'h1234_5678, 20, 16'h0000, 0, ST_HIT, 16'h0000, 0);
		add_row(CMD_INSERT, 32'h0000_0000, 0, 16'h0000, 1, ST_INS_OK, 16'h0000, 0);
		add_row(CMD_LOOKUP, 32'hC000_0000, 2, 16'h0000, 0, ST_HIT, 16'h0000, 0);
		add_row(CMD_LOOKUP, 32'h0000_0000, 1, 16'h0000, 0, ST_HIT, 16'h0000, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want, 1'b0);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == HOLD_AT)
				hold_pending = 1'b1;
			r = next_request(i >= GROW_ITEMS);
			offer(r, 1'b0, none, i == DRAIN_AT);
		end
		req_valid <= 1'b0;

		while (expected_routes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== unibit_trie_longest_prefix_match.f =====
rtl/utlpm_pkg.sv
rtl/utlpm_datapath.sv
rtl/utlpm_ctrl.sv
rtl/unibit_trie_longest_prefix_match.sv
sim/tb.sv
